### design/shared_buffer_admission_pfc_defines.svh
// Assertion macros used by the admission unit design file
`ifndef SHARED_BUFFER_ADMISSION_PFC_DEFINES_SVH
`define SHARED_BUFFER_ADMISSION_PFC_DEFINES_SVH
`ifndef SYNTHESIS
`define SBAPFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SBAPFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBAPFC_ASSERT(lbl, prop, msg)
`define SBAPFC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### design/sbapfc_pkg.sv
package sbapfc_pkg;

  localparam logic [1:0] CMD_IN_ARR = 2'd0;
  localparam logic [1:0] CMD_EG_ARR = 2'd1;
  localparam logic [1:0] CMD_IN_DEP = 2'd2;
  localparam logic [1:0] CMD_EG_DEP = 2'd3;

  localparam logic [2:0] REG_BUFFER_POOL  = 3'd0;
  localparam logic [2:0] REG_INGRESS_POOL = 3'd1;
  localparam logic [2:0] REG_EG_LOSSY     = 3'd2;
  localparam logic [2:0] REG_EG_LOSSLESS  = 3'd3;
  localparam logic [2:0] REG_RESERVE      = 3'd4;
  localparam logic [2:0] REG_ALPHA_IN     = 3'd5;
  localparam logic [2:0] REG_ALPHA_EG     = 3'd6;
  localparam logic [2:0] REG_HEADROOM     = 3'd7;

  localparam int THR_W = 40;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  port;
    logic [2:0]  queue;
    logic [13:0] size;
    logic        lossless;
  } in_item_t;

  typedef struct packed {
    logic        admitted;
    logic        pause_send;
    logic        resume_send;
    logic [31:0] queue_bytes;
  } out_item_t;

  typedef struct packed {
    logic [31:0] ing_bytes;
    logic [31:0] egr_bytes;
    logic [31:0] hdr_used;
    logic        paused;
  } entry_t;

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] sub_sat(input logic [31:0] a, input logic [31:0] b);
    return (a > b) ? (a - b) : 32'd0;
  endfunction

endpackage

### design/sbapfc_mem.sv
module sbapfc_mem import sbapfc_pkg::*; #(
  parameter int NQ = 256,
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data
);

  entry_t          mem [NQ];
  entry_t          raw_r;
  logic [NQ-1:0]   vld_r;
  logic            rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      raw_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? raw_r : '0;

endmodule

### design/sbapfc_thr.sv
module sbapfc_thr import sbapfc_pkg::*; (
  input  logic             clk,
  input  logic [15:0]      alpha,
  input  logic [31:0]      pool,
  input  logic [31:0]      used,
  output logic [THR_W-1:0] thr
);

  logic [31:0]      rem;
  logic [47:0]      prod;
  logic [THR_W-1:0] thr_r;

  assign rem  = (pool > used) ? (pool - used) : 32'd0;
  assign prod = {32'd0, alpha} * {16'd0, rem};

  always_ff @(posedge clk) begin
    thr_r <= prod[47:8];
  end

  assign thr = thr_r;

endmodule

### design/shared_buffer_admission_pfc.sv
// Shared-buffer admission unit with dynamic thresholds and PFC headroom.
// Input channel (in_valid, in_data, in_stall): one packet event per beat,
// taken when in_valid is high and in_stall low. in_stall is high from the
// accepting edge until the result is loaded into the output register.
// Output channel (out_valid, out_data, out_stall): one result beat per event,
// held in an output register until the receiver drops out_stall; a further
// event may be taken while that result still waits.
// Egress events pass LOAD, CHECK and WB; ingress lossy events and ingress
// drops add THR2, lossless departures HADD and THR2, lossless arrivals THR1,
// HUPD, HADD and THR2; an out-of-range port or queue goes from LOAD to WB.
// An event takes one memory read, one pass through the threshold multiplier
// per threshold used, and one write unless its port or queue is out of range.
// An event is taken only once the last result is loaded; a result held by a
// stalled receiver keeps the next event in write-back until out_stall drops.
// Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready;
// write it only while no event is in flight.
// Reset restores register defaults and marks every per-queue entry as unwritten,
// so it reads as zero; no clearing pass is needed.
module shared_buffer_admission_pfc import sbapfc_pkg::*; #(
  parameter int PORTS            = 32,
  parameter int QUEUES           = 8,
  parameter int XON_BYTES        = 1248,
  parameter int XON_OFFSET_BYTES = 2496
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  in_item_t   in_data,
  output logic       in_stall,
  output logic       out_valid,
  output out_item_t  out_data,
  input  logic       out_stall,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);

`include "shared_buffer_admission_pfc_defines.svh"

  localparam int NQ = PORTS * QUEUES;
  localparam int AW = (NQ > 1) ? $clog2(NQ) : 1;
  localparam logic [31:0] XON  = 32'(XON_BYTES);
  localparam logic [32:0] XOFF = 33'(XON_OFFSET_BYTES);
  localparam logic [31:0] NQ_C = 32'(NQ);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LOAD  = 4'd1;
  localparam logic [3:0] ST_CHECK = 4'd2;
  localparam logic [3:0] ST_THR1  = 4'd3;
  localparam logic [3:0] ST_HUPD  = 4'd4;
  localparam logic [3:0] ST_HADD  = 4'd5;
  localparam logic [3:0] ST_THR2  = 4'd6;
  localparam logic [3:0] ST_WB    = 4'd7;

  logic [31:0] bpool_r, ipool_r, elsy_pool_r, elsl_pool_r;
  logic [19:0] rsv_r, hpq_r;
  logic [15:0] a_in_r, a_eg_r;

  logic [3:0]  st_r, st_nxt;
  in_item_t    item_r;
  logic [AW-1:0] addr_r;
  logic        oor_r;
  logic [31:0] ib_r, ib_nxt, eb_r, eb_nxt, hq_r, hq_nxt;
  logic        pz_r;
  logic [31:0] tot_r, tot_nxt, htu_r, htu_nxt, elsy_r, elsy_nxt, elsl_r, elsl_nxt;
  logic        adm_r, adm_nxt;
  logic        out_valid_r;
  out_item_t   out_data_r;

  logic          in_fire, out_free, wb_go;
  logic [AW-1:0] in_addr;
  entry_t        rd_data, wr_data;
  logic [THR_W-1:0] thr;
  logic [15:0]   t_alpha;
  logic [31:0]   t_pool, t_used;
  logic          egr;
  logic [31:0]   pool_used, hrt, eg_pool, eg_used;
  logic [32:0]   sz, s_ib, s_eb, s_hq, s_htu, s_tot, s_pu, s_egu, ip_hrt;
  logic          bad;
  logic          ps, rs, pz_new;

  assign in_fire   = in_valid && !in_stall;
  assign in_stall  = (st_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign wb_go     = (st_r == ST_WB) && out_free;
  assign in_addr   = AW'(AW'(in_data.port) * AW'(QUEUES)) + AW'(in_data.queue);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpool_r     <= 32'd25165824;
      ipool_r     <= 32'd18874368;
      elsy_pool_r <= 32'd14680064;
      elsl_pool_r <= 32'd25165824;
      rsv_r       <= 20'd1248;
      a_in_r      <= 16'd256;
      a_eg_r      <= 16'd256;
      hpq_r       <= 20'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BUFFER_POOL:  bpool_r     <= cfg_data;
        REG_INGRESS_POOL: ipool_r     <= cfg_data;
        REG_EG_LOSSY:     elsy_pool_r <= cfg_data;
        REG_EG_LOSSLESS:  elsl_pool_r <= cfg_data;
        REG_RESERVE:      rsv_r       <= cfg_data[19:0];
        REG_ALPHA_IN:     a_in_r      <= cfg_data[15:0];
        REG_ALPHA_EG:     a_eg_r      <= cfg_data[15:0];
        REG_HEADROOM:     hpq_r       <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  sbapfc_mem #(.NQ(NQ), .AW(AW)) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (in_addr),
    .rd_data (rd_data),
    .wr_en   (wb_go && !oor_r),
    .wr_addr (addr_r),
    .wr_data (wr_data)
  );

  assign egr       = item_r.cmd[0];
  assign pool_used = tot_r - htu_r;
  assign eg_pool   = item_r.lossless ? elsl_pool_r : elsy_pool_r;
  assign eg_used   = item_r.lossless ? elsl_r : elsy_r;
  assign t_alpha   = egr ? a_eg_r : a_in_r;
  assign t_pool    = egr ? eg_pool : ipool_r;
  assign t_used    = egr ? eg_used : pool_used;

  sbapfc_thr u_thr (
    .clk   (clk),
    .alpha (t_alpha),
    .pool  (t_pool),
    .used  (t_used),
    .thr   (thr)
  );

  assign hrt    = 32'({12'd0, hpq_r} * NQ_C);
  assign sz     = {19'd0, item_r.size};
  assign s_ib   = sz + {1'b0, ib_r};
  assign s_eb   = sz + {1'b0, eb_r};
  assign s_hq   = sz + {1'b0, hq_r};
  assign s_htu  = sz + {1'b0, htu_r};
  assign s_tot  = sz + {1'b0, tot_r};
  assign s_pu   = sz + {1'b0, pool_used};
  assign s_egu  = sz + {1'b0, eg_used};
  assign ip_hrt = {1'b0, ipool_r} + {1'b0, hrt};

  always_comb begin
    if (egr) begin
      bad = ((THR_W'(s_eb) > thr) && (s_eb > 33'(rsv_r))) ||
            (s_egu > {1'b0, eg_pool}) || (s_tot > {1'b0, bpool_r});
    end else if (!item_r.lossless) begin
      bad = ((THR_W'(s_ib) > thr) && (s_ib > 33'(rsv_r))) ||
            (s_pu > {1'b0, ipool_r}) || (s_tot > {1'b0, bpool_r});
    end else begin
      bad = ((s_ib > 33'(rsv_r)) && (s_hq > 33'(hpq_r)) && (hq_r != 32'd0)) ||
            ((s_htu >= {1'b0, hrt}) && (hq_r != 32'd0)) ||
            (s_tot > ip_hrt) || (s_tot > {1'b0, bpool_r});
    end
  end

  always_comb begin
    st_nxt   = st_r;
    ib_nxt   = ib_r;
    eb_nxt   = eb_r;
    hq_nxt   = hq_r;
    tot_nxt  = tot_r;
    htu_nxt  = htu_r;
    elsy_nxt = elsy_r;
    elsl_nxt = elsl_r;
    adm_nxt  = adm_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          st_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        st_nxt = oor_r ? ST_WB : ST_CHECK;
        ib_nxt = rd_data.ing_bytes;
        eb_nxt = rd_data.egr_bytes;
        hq_nxt = rd_data.hdr_used;
      end
      ST_CHECK: begin
        adm_nxt = 1'b1;
        case (item_r.cmd)
          CMD_IN_ARR: begin
            if (bad) begin
              adm_nxt = 1'b0;
              st_nxt  = ST_THR2;
            end else begin
              ib_nxt  = add_sat(ib_r, sz[31:0]);
              tot_nxt = add_sat(tot_r, sz[31:0]);
              if (item_r.lossless) begin
                htu_nxt = sub_sat(htu_r, hq_r);
                st_nxt  = ST_THR1;
              end else begin
                st_nxt = ST_THR2;
              end
            end
          end
          CMD_IN_DEP: begin
            ib_nxt  = sub_sat(ib_r, sz[31:0]);
            tot_nxt = sub_sat(tot_r, sz[31:0]);
            if (item_r.lossless) begin
              htu_nxt = sub_sat(htu_r, hq_r);
              hq_nxt  = sub_sat(hq_r, sz[31:0]);
              st_nxt  = ST_HADD;
            end else begin
              st_nxt = ST_THR2;
            end
          end
          CMD_EG_ARR: begin
            st_nxt = ST_WB;
            if (bad) begin
              adm_nxt = 1'b0;
            end else begin
              eb_nxt = add_sat(eb_r, sz[31:0]);
              if (item_r.lossless) begin
                elsl_nxt = add_sat(elsl_r, sz[31:0]);
              end else begin
                elsy_nxt = add_sat(elsy_r, sz[31:0]);
              end
            end
          end
          default: begin
            st_nxt = ST_WB;
            eb_nxt = sub_sat(eb_r, sz[31:0]);
            if (item_r.lossless) begin
              elsl_nxt = sub_sat(elsl_r, sz[31:0]);
            end else begin
              elsy_nxt = sub_sat(elsy_r, sz[31:0]);
            end
          end
        endcase
      end
      ST_THR1: st_nxt = ST_HUPD;
      ST_HUPD: begin
        st_nxt = ST_HADD;
        if (hq_r == 32'd0) begin
          hq_nxt = (THR_W'(ib_r) > thr) ? (ib_r - thr[31:0]) : 32'd0;
        end else begin
          hq_nxt = add_sat(hq_r, sz[31:0]);
        end
      end
      ST_HADD: begin
        htu_nxt = add_sat(htu_r, hq_r);
        st_nxt  = ST_THR2;
      end
      ST_THR2: st_nxt = ST_WB;
      ST_WB: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ps     = 1'b0;
    rs     = 1'b0;
    pz_new = pz_r;
    if (!egr) begin
      if (!pz_r && (hq_r != 32'd0)) begin
        pz_new = 1'b1;
        ps     = 1'b1;
      end else if (pz_r && (hq_r == 32'd0) &&
                   ((ib_r < XON) || (THR_W'({1'b0, ib_r} + XOFF) <= thr))) begin
        pz_new = 1'b0;
        rs     = 1'b1;
      end
    end
  end

  assign wr_data = '{ing_bytes: ib_r, egr_bytes: eb_r, hdr_used: hq_r, paused: pz_new};

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_data;
      addr_r <= in_addr;
      oor_r  <= (32'(in_data.port) >= 32'(PORTS)) || (32'(in_data.queue) >= 32'(QUEUES));
    end
    if (st_r == ST_LOAD) begin
      pz_r <= rd_data.paused;
    end
    ib_r  <= ib_nxt;
    eb_r  <= eb_nxt;
    hq_r  <= hq_nxt;
    adm_r <= adm_nxt;
    if (wb_go) begin
      if (oor_r) begin
        out_data_r <= '{admitted: item_r.cmd[1], pause_send: 1'b0,
                        resume_send: 1'b0, queue_bytes: 32'd0};
      end else begin
        out_data_r <= '{admitted: adm_r, pause_send: ps, resume_send: rs,
                        queue_bytes: egr ? eb_r : ib_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      tot_r       <= 32'd0;
      htu_r       <= 32'd0;
      elsy_r      <= 32'd0;
      elsl_r      <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      tot_r  <= tot_nxt;
      htu_r  <= htu_nxt;
      elsy_r <= elsy_nxt;
      elsl_r <= elsl_nxt;
      if (wb_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SBAPFC_ASSERT(a_no_pause_and_resume, out_valid_r |-> !(out_data_r.pause_send && out_data_r.resume_send), "pause and resume in one beat")
  `SBAPFC_ASSERT(a_busy_after_accept, in_fire |=> (st_r == ST_LOAD), "accepted beat did not start a read")
  `SBAPFC_ASSERT(a_result_from_wb, $rose(out_valid_r) |-> ($past(st_r) == ST_WB), "result without write-back")

endmodule

### test/tb_shared_buffer_admission_pfc.sv
`timescale 1ns / 100ps

module tb_shared_buffer_admission_pfc;
  import sbapfc_pkg::*;

  localparam int NQ = 256;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RAND_PER_PHASE = 220;
  localparam bit [63:0] CNT_MAX = 64'hFFFF_FFFF;

  typedef struct {
    in_item_t  beat;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  in_item_t   in_data;
  logic       in_stall;
  logic       out_valid;
  out_item_t  out_data;
  logic       out_stall;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  bit [63:0] buf_pool, ing_pool, eg_lossy_pool, eg_ll_pool;
  bit [63:0] q_reserve, alpha_in, alpha_eg, hdr_per_q;
  bit [63:0] ing_bytes [NQ];
  bit [63:0] egr_bytes [NQ];
  bit [63:0] hdr_q_used [NQ];
  bit        q_paused [NQ];
  bit [63:0] total_used, hdr_total_used, eg_lossy_used, eg_ll_used;

  out_item_t result_q [$];
  int        mismatches;
  int        quiet_cycles;
  bit        in_idle_en;
  bit        out_idle_en;

  shared_buffer_admission_pfc i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic bit [63:0] sat_add(bit [63:0] a, bit [63:0] b);
    bit [63:0] s;
    s = a + b;
    return (s > CNT_MAX) ? CNT_MAX : s;
  endfunction

  function automatic bit [63:0] sat_sub(bit [63:0] a, bit [63:0] b);
    return (a > b) ? a - b : 64'd0;
  endfunction

  function automatic bit [63:0] dyn_limit(bit [63:0] alpha, bit [63:0] pool, bit [63:0] used);
    if (pool <= used) return 64'd0;
    return (alpha * (pool - used)) >> 8;
  endfunction

  function automatic bit [63:0] shared_used();
    return (total_used - hdr_total_used) & CNT_MAX;
  endfunction

  function automatic bit [63:0] ing_limit();
    return dyn_limit(alpha_in, ing_pool, shared_used());
  endfunction

  function automatic bit [63:0] hdr_pool();
    return hdr_per_q * 64'd256;
  endfunction

  function automatic bit ingress_admit(int q, bit [63:0] sz, bit ll);
    bit [63:0] ib, hq;
    ib = ing_bytes[q];
    hq = hdr_q_used[q];
    if (!ll)
      return !((sz + ib > ing_limit() && sz + ib > q_reserve) ||
               sz + shared_used() > ing_pool || sz + total_used > buf_pool);
    return !((sz + ib > q_reserve && sz + hq > hdr_per_q && hq > 0) ||
             (sz + hdr_total_used >= hdr_pool() && hq > 0) ||
             sz + total_used > ing_pool + hdr_pool() ||
             sz + total_used > buf_pool);
  endfunction

  function automatic bit egress_admit(int q, bit [63:0] sz, bit ll);
    bit [63:0] pool, used, eb;
    eb = egr_bytes[q];
    pool = ll ? eg_ll_pool : eg_lossy_pool;
    used = ll ? eg_ll_used : eg_lossy_used;
    return !((sz + eb > dyn_limit(alpha_eg, pool, used) && sz + eb > q_reserve) ||
             sz + used > pool || sz + total_used > buf_pool);
  endfunction

  function automatic out_item_t admission_predict(in_item_t it);
    out_item_t r;
    int q;
    bit [63:0] sz, lim;
    r = '0;
    r.admitted = 1'b1;
    q = int'(it.port) * 8 + int'(it.queue);
    sz = 64'(it.size);
    if (it.cmd == CMD_IN_ARR || it.cmd == CMD_IN_DEP) begin
      if (it.cmd == CMD_IN_ARR) begin
        if (ingress_admit(q, sz, it.lossless)) begin
          ing_bytes[q] = sat_add(ing_bytes[q], sz);
          total_used = sat_add(total_used, sz);
          if (it.lossless) begin
            hdr_total_used = sat_sub(hdr_total_used, hdr_q_used[q]);
            lim = ing_limit();
            if (hdr_q_used[q] == 0) begin
              if (ing_bytes[q] > lim) hdr_q_used[q] = ing_bytes[q] - lim;
            end else begin
              hdr_q_used[q] = sat_add(hdr_q_used[q], sz);
            end
            hdr_total_used = sat_add(hdr_total_used, hdr_q_used[q]);
          end
        end else begin
          r.admitted = 1'b0;
        end
      end else begin
        ing_bytes[q] = sat_sub(ing_bytes[q], sz);
        total_used = sat_sub(total_used, sz);
        if (it.lossless) begin
          hdr_total_used = sat_sub(hdr_total_used, hdr_q_used[q]);
          hdr_q_used[q] = sat_sub(hdr_q_used[q], sz);
          hdr_total_used = sat_add(hdr_total_used, hdr_q_used[q]);
        end
      end
      if (!q_paused[q] && hdr_q_used[q] > 0) begin
        q_paused[q] = 1'b1;
        r.pause_send = 1'b1;
      end else if (q_paused[q] && hdr_q_used[q] == 0 &&
                   (ing_bytes[q] < 64'd1248 || ing_bytes[q] + 64'd2496 <= ing_limit())) begin
        q_paused[q] = 1'b0;
        r.resume_send = 1'b1;
      end
      r.queue_bytes = ing_bytes[q][31:0];
    end else begin
      if (it.cmd == CMD_EG_ARR) begin
        if (egress_admit(q, sz, it.lossless)) begin
          egr_bytes[q] = sat_add(egr_bytes[q], sz);
          if (it.lossless) eg_ll_used = sat_add(eg_ll_used, sz);
          else eg_lossy_used = sat_add(eg_lossy_used, sz);
        end else begin
          r.admitted = 1'b0;
        end
      end else begin
        egr_bytes[q] = sat_sub(egr_bytes[q], sz);
        if (it.lossless) eg_ll_used = sat_sub(eg_ll_used, sz);
        else eg_lossy_used = sat_sub(eg_lossy_used, sz);
      end
      r.queue_bytes = egr_bytes[q][31:0];
    end
    return r;
  endfunction

  task automatic send_event(in_item_t it, bit typed, out_item_t want);
    out_item_t p;
    if (in_idle_en)
      while ($urandom_range(99) < 37) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    p = admission_predict(it);
    result_q.push_back(typed ? want : p);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BUFFER_POOL:  buf_pool = 64'(val);
      REG_INGRESS_POOL: ing_pool = 64'(val);
      REG_EG_LOSSY:     eg_lossy_pool = 64'(val);
      REG_EG_LOSSLESS:  eg_ll_pool = 64'(val);
      REG_RESERVE:      q_reserve = 64'(val[19:0]);
      REG_ALPHA_IN:     alpha_in = 64'(val[15:0]);
      REG_ALPHA_EG:     alpha_eg = 64'(val[15:0]);
      default:          hdr_per_q = 64'(val[19:0]);
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(logic [31:0] bp, logic [31:0] ip, logic [31:0] elp,
                             logic [31:0] ellp, logic [31:0] res, logic [31:0] ai,
                             logic [31:0] ae, logic [31:0] hr);
    write_reg(REG_BUFFER_POOL, bp);
    write_reg(REG_INGRESS_POOL, ip);
    write_reg(REG_EG_LOSSY, elp);
    write_reg(REG_EG_LOSSLESS, ellp);
    write_reg(REG_RESERVE, res);
    write_reg(REG_ALPHA_IN, ai);
    write_reg(REG_ALPHA_EG, ae);
    write_reg(REG_HEADROOM, hr);
  endtask

  task automatic random_events(int n, int hot_size);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it.cmd = 2'($urandom_range(3));
      it.port = ($urandom_range(99) < 80) ? 5'($urandom_range(3)) : 5'($urandom_range(31));
      it.queue = ($urandom_range(99) < 80) ? 3'($urandom_range(1)) : 3'($urandom_range(7));
      case ($urandom_range(19))
        0: it.size = 14'h3FFF;
        1: it.size = 14'd0;
        2: it.size = 14'($urandom_range(16383));
        default: it.size = 14'($urandom_range(hot_size, 1));
      endcase
      it.lossless = ($urandom_range(99) < 60);
      send_event(it, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    out_item_t w;
    out_stall <= out_idle_en && ($urandom_range(99) < 37);
    if (in_valid && !in_stall || out_valid && !out_stall || cfg_valid && cfg_ready)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_data);
      end else begin
        w = result_q.pop_front();
        if (out_data.admitted !== w.admitted || out_data.pause_send !== w.pause_send ||
            out_data.resume_send !== w.resume_send || out_data.queue_bytes !== w.queue_bytes) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", w, out_data);
        end
      end
    end
  end

  initial begin
    dir_row_t rows [$];
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    quiet_cycles = 0;
    in_idle_en = 1'b1;
    out_idle_en = 1'b1;
    buf_pool = 64'd25165824;
    ing_pool = 64'd18874368;
    eg_lossy_pool = 64'd14680064;
    eg_ll_pool = 64'd25165824;
    q_reserve = 64'd1248;
    alpha_in = 64'd256;
    alpha_eg = 64'd256;
    hdr_per_q = 64'd0;
    foreach (ing_bytes[i]) begin
      ing_bytes[i] = 0;
      egr_bytes[i] = 0;
      hdr_q_used[i] = 0;
      q_paused[i] = 0;
    end
    total_used = 0;
    hdr_total_used = 0;
    eg_lossy_used = 0;
    eg_ll_used = 0;

    rows = '{
      '{'{CMD_IN_ARR, 5'd0, 3'd0, 14'd100, 1'b0}, 1'b1, '{1'b1, 1'b0, 1'b0, 32'd100}},
      '{'{CMD_IN_ARR, 5'd31, 3'd7, 14'h3FFF, 1'b0}, 1'b1, '{1'b1, 1'b0, 1'b0, 32'd16383}},
      '{'{CMD_IN_DEP, 5'd31, 3'd7, 14'h3FFF, 1'b0}, 1'b1, '{1'b1, 1'b0, 1'b0, 32'd0}},
      '{'{CMD_IN_DEP, 5'd0, 3'd1, 14'd500, 1'b0}, 1'b1, '{1'b1, 1'b0, 1'b0, 32'd0}},
      '{'{CMD_EG_ARR, 5'd0, 3'd0, 14'h3FFF, 1'b0}, 1'b1, '{1'b1, 1'b0, 1'b0, 32'd16383}},
      '{'{CMD_EG_ARR, 5'd5, 3'd3, 14'd1, 1'b1}, 1'b1, '{1'b1, 1'b0, 1'b0, 32'd1}},
      '{'{CMD_EG_DEP, 5'd5, 3'd3, 14'h3FFF, 1'b1}, 1'b1, '{1'b1, 1'b0, 1'b0, 32'd0}},
      '{'{CMD_EG_DEP, 5'd0, 3'd0, 14'd100, 1'b0}, 1'b1, '{1'b1, 1'b0, 1'b0, 32'd16283}},
      '{'{CMD_IN_ARR, 5'd2, 3'd2, 14'd0, 1'b1}, 1'b1, '{1'b1, 1'b0, 1'b0, 32'd0}},
      '{'{CMD_IN_ARR, 5'd2, 3'd2, 14'h3FFF, 1'b1}, 1'b1, '{1'b1, 1'b0, 1'b0, 32'd16383}},
      '{'{CMD_IN_DEP, 5'd2, 3'd2, 14'h3FFF, 1'b1}, 1'b1, '{1'b1, 1'b0, 1'b0, 32'd0}},
      '{'{CMD_IN_ARR, 5'd21, 3'd5, 14'h2AAA, 1'b1}, 1'b0, '0},
      '{'{CMD_EG_ARR, 5'd10, 3'd2, 14'h1555, 1'b0}, 1'b0, '0},
      '{'{CMD_IN_DEP, 5'd21, 3'd5, 14'h1555, 1'b0}, 1'b0, '0},
      '{'{CMD_EG_DEP, 5'd10, 3'd2, 14'h2AAA, 1'b1}, 1'b0, '0}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_event(rows[i].beat, rows[i].typed, rows[i].want);
    random_events(RAND_PER_PHASE, 4000);
    drain();

    load_config(32'd200000, 32'd60000, 32'd40000, 32'd30000,
                32'hFFF0_07D0, 32'hFFFF_0020, 32'hFFFF_0080, 32'hFFF0_4E20);
    random_events(RAND_PER_PHASE, 6000);
    drain();

    in_idle_en = 1'b0;
    out_idle_en = 1'b0;
    load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'h000F_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 32'h000F_FFFF);
    random_events(150, 16383);
    in_idle_en = 1'b1;
    out_idle_en = 1'b1;
    random_events(70, 16383);
    drain();

    load_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    random_events(RAND_PER_PHASE, 3000);
    drain();

    load_config(32'd120000, 32'd50000, 32'd25000, 32'd45000,
                32'd600, 32'd64, 32'd512, 32'd3000);
    random_events(RAND_PER_PHASE, 5000);
    drain();

    if (mismatches == 0 && result_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
